### hdl/spvp_pkg.sv
// spin-in-place velocity profile: shared types, codes and constants
// used by the top level, the square-root unit and the checker
`timescale 1ns / 1ps

package spvp_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_TARGET_ANGLE = 3'd0;
    localparam logic [2:0] CFG_MAX_VELOCITY = 3'd1;
    localparam logic [2:0] CFG_MIN_VELOCITY = 3'd2;
    localparam logic [2:0] CFG_ACCEL_LIMIT  = 3'd3;
    localparam logic [2:0] CFG_TIME_ALLOW   = 3'd4;

    // register reset values
    localparam logic [14:0] TARGET_ANGLE_RST = 15'd6431;
    localparam logic [14:0] MAX_VELOCITY_RST = 15'd4096;
    localparam logic [14:0] MIN_VELOCITY_RST = 15'd1638;
    localparam logic [14:0] ACCEL_LIMIT_RST  = 15'd13107;
    localparam logic [15:0] TIME_ALLOW_RST   = 16'd0;

    // angle constants, q4.12 radians
    localparam logic [15:0]        PI_Q12     = 16'd12868;
    localparam logic signed [16:0] TWO_PI_Q12 = 17'sd25736;
    localparam logic signed [18:0] ACC_MAX    = 19'sd131071;
    localparam logic signed [18:0] ACC_MIN    = -19'sd131072;

    // width of the packed payloads
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // square-root unit: radicand bits and steps (one result bit per step)
    localparam int SQRT_W     = 32;
    localparam int SQRT_STEPS = SQRT_W / 2;

    // input action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // result status codes
    typedef enum logic [2:0] {
        STAT_IDLE      = 3'd0,
        STAT_RUNNING   = 3'd1,
        STAT_SUCCEEDED = 3'd2,
        STAT_TIMED_OUT = 3'd3,
        STAT_COLLISION = 3'd4
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UNWRAP,
        ST_REMAIN,
        ST_MUL,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_CLAMP,
        ST_EMIT
    } state_t;

    // control into the square-root unit
    typedef struct packed {
        logic start;
    } sqrt_ctrl_t;

    // status back from the square-root unit
    typedef struct packed {
        logic busy;
        logic done;
    } sqrt_stat_t;

endpackage

### hdl/spvp_sqrt.sv
// iterative integer square root, one result bit per cycle
// depends on spvp_pkg for widths and the control/status structs
`timescale 1ns / 1ps

module spvp_sqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  spvp_pkg::sqrt_ctrl_t         ctrl,
    input  logic [spvp_pkg::SQRT_W-1:0]  radicand,
    output spvp_pkg::sqrt_stat_t         stat,
    output logic [spvp_pkg::SQRT_W/2-1:0] root
);
    import spvp_pkg::*;

    localparam int STEP_W = $clog2(SQRT_STEPS);

    logic [SQRT_W-1:0] rem_reg,  rem_next;
    logic [SQRT_W-1:0] root_reg, root_next;
    logic [SQRT_W-1:0] bit_reg,  bit_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [SQRT_W:0]   trial;

    // one restoring step: try subtracting root + bit
    always_comb begin
        trial     = {1'b0, root_reg} + {1'b0, bit_reg};
        rem_next  = rem_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start) begin
            rem_next  = radicand;
            root_next = '0;
            bit_next  = {2'b01, {(SQRT_W-2){1'b0}}};
            step_next = STEP_W'(SQRT_STEPS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if ({1'b0, rem_reg} >= trial) begin
                rem_next  = rem_reg - trial[SQRT_W-1:0];
                root_next = (root_reg >> 1) + bit_reg;
            end else begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    // control flags reset, working registers do not
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        step_reg <= step_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg[SQRT_W/2-1:0];

endmodule

### hdl/spin_in_place_velocity_profile.sv
// top level of the in-place rotation speed controller
// depends on spvp_pkg and instantiates spvp_sqrt
`timescale 1ns / 1ps

// Rotation controller with a decelerating speed profile, q4.12 fixed point.
// Input stream (s_): s_tuser is the action (0 start, 1 control tick); s_tdata
// carries yaw, turn_left, goal_angle and collision_ahead. Each transaction
// gives exactly one result transaction on the m_ side (status, angular
// velocity, travelled angle).
// Configuration: cfg_valid/cfg_index/cfg_data write one register per cycle;
// cfg_ready is always high. Write only while the block is idle.
// Steps: a start, an idle tick and a timeout go from acceptance through the
// unwrap step to the emit step, an immediate success also through the
// remaining-angle step; a running tick goes through unwrap, remaining-angle,
// multiply, the 16-step square-root unit (one root bit per cycle) and clamp.
// Items: one at a time; s_tready is high only in the idle state, so the next
// item is taken only once the previous result has gone to the result register.
// The result register holds a finished result while m_tready is low; the
// next item can be accepted and worked on meanwhile, and waits only at the
// end for the result register to drain.
// Reset (aresetn low, synchronous): registers back to their defaults,
// phase idle, accumulated angle zero, no result pending.

module spin_in_place_velocity_profile (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [14:0] yaw, [15] turn_left, [31:16] goal_angle, [32] collision_ahead
    input  logic [spvp_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] action
    input  logic                              s_tuser,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [2:0] status, [18:3] angular_velocity, [36:19] travelled_angle
    output logic [spvp_pkg::M_TDATA_W-1:0]    m_tdata,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [2:0]                        cfg_index,
    input  logic [15:0]                       cfg_data
);
    import spvp_pkg::*;

    // configuration registers
    logic [14:0] target_reg, vmax_reg, vmin_reg, accel_reg;
    logic [15:0] tmo_reg;

    // controller state
    state_t             state_reg, state_next;
    logic               phase_reg, phase_next;
    logic signed [14:0] prev_yaw_reg, prev_yaw_next;
    logic signed [17:0] acc_reg, acc_next;
    logic signed [16:0] cmd_reg, cmd_next;
    logic [15:0]        elapsed_reg, elapsed_next;

    // captured input item
    logic               act_reg;
    logic signed [14:0] yaw_reg;
    logic               turn_reg;
    logic signed [15:0] goal_reg;
    logic               coll_reg;

    // working registers
    logic [15:0]        rem_reg, rem_next;
    logic [31:0]        prod_reg, prod_next;
    status_t            res_status_reg, res_status_next;
    logic signed [15:0] res_vel_reg, res_vel_next;

    // result register
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;

    // square-root unit
    sqrt_ctrl_t  sq_ctrl;
    sqrt_stat_t  sq_stat;
    logic [15:0] sq_root;

    // combinational arithmetic
    logic [15:0]        goal_abs, mag;
    logic signed [15:0] delta;
    logic [15:0]        delta_abs;
    logic signed [16:0] wrap_mag, delta_w;
    logic signed [18:0] acc_sum;
    logic signed [17:0] acc_sat;
    logic [16:0]        cmd_abs;
    logic [17:0]        acc_abs;
    logic signed [18:0] remaining;
    logic [15:0]        v_lo, v_clamp;
    logic               timed_out, unwrap_exit, remain_exit, out_free;

    logic s_acc;

    assign s_acc     = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;

    // arithmetic of the unwrap, remaining-angle and clamp steps
    always_comb begin
        goal_abs  = goal_reg[15] ? 16'(-goal_reg) : 16'(goal_reg);
        mag       = (target_reg != '0) ? {1'b0, target_reg} : goal_abs;

        delta     = 16'(signed'({yaw_reg[14], yaw_reg}) - signed'({prev_yaw_reg[14],
                                                                   prev_yaw_reg}));
        delta_abs = delta[15] ? 16'(-delta) : 16'(delta);
        wrap_mag  = TWO_PI_Q12 - signed'({1'b0, delta_abs});
        if (delta_abs > PI_Q12) begin
            delta_w = prev_yaw_reg[14] ? 17'(-wrap_mag) : wrap_mag;
        end else begin
            delta_w = 17'(delta);
        end
        acc_sum = 19'(acc_reg) + 19'(delta_w);
        if (acc_sum > ACC_MAX) begin
            acc_sat = 18'(ACC_MAX);
        end else if (acc_sum < ACC_MIN) begin
            acc_sat = 18'(ACC_MIN);
        end else begin
            acc_sat = acc_sum[17:0];
        end

        cmd_abs   = cmd_reg[16] ? 17'(-cmd_reg) : 17'(cmd_reg);
        acc_abs   = acc_reg[17] ? 18'(-acc_reg) : 18'(acc_reg);
        remaining = signed'({2'b00, cmd_abs}) - signed'({1'b0, acc_abs});

        v_lo    = (sq_root < {1'b0, vmin_reg}) ? {1'b0, vmin_reg} : sq_root;
        v_clamp = (v_lo > {1'b0, vmax_reg}) ? {1'b0, vmax_reg} : v_lo;

        timed_out   = (tmo_reg != '0) && (elapsed_reg >= tmo_reg);
        unwrap_exit = (act_reg == ACT_START) || !phase_reg || timed_out;
        remain_exit = (remaining < 19'sd1);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_acc) state_next = ST_UNWRAP;
            ST_UNWRAP:    state_next = unwrap_exit ? ST_EMIT : ST_REMAIN;
            ST_REMAIN:    state_next = remain_exit ? ST_EMIT : ST_MUL;
            ST_MUL:       state_next = ST_ROOT_GO;
            ST_ROOT_GO:   state_next = ST_ROOT_WAIT;
            ST_ROOT_WAIT: if (sq_stat.done) state_next = ST_CLAMP;
            ST_CLAMP:     state_next = ST_EMIT;
            ST_EMIT:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs of each step
    always_comb begin
        phase_next      = phase_reg;
        prev_yaw_next   = prev_yaw_reg;
        acc_next        = acc_reg;
        cmd_next        = cmd_reg;
        elapsed_next    = elapsed_reg;
        rem_next        = rem_reg;
        prod_next       = prod_reg;
        res_status_next = res_status_reg;
        res_vel_next    = res_vel_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        sq_ctrl.start   = 1'b0;
        case (state_reg)
            ST_UNWRAP: begin
                res_vel_next = '0;
                if (act_reg == ACT_START) begin
                    prev_yaw_next = yaw_reg;
                    acc_next      = '0;
                    if (mag == '0) begin
                        phase_next      = 1'b0;
                        res_status_next = STAT_SUCCEEDED;
                    end else begin
                        cmd_next        = turn_reg ? signed'({1'b0, mag})
                                                   : 17'(-signed'({1'b0, mag}));
                        elapsed_next    = '0;
                        phase_next      = 1'b1;
                        res_status_next = STAT_RUNNING;
                    end
                end else if (!phase_reg) begin
                    res_status_next = STAT_IDLE;
                end else if (timed_out) begin
                    phase_next      = 1'b0;
                    res_status_next = STAT_TIMED_OUT;
                end else begin
                    if (elapsed_reg != 16'hFFFF) elapsed_next = elapsed_reg + 1'b1;
                    acc_next      = acc_sat;
                    prev_yaw_next = yaw_reg;
                end
            end
            ST_REMAIN: begin
                if (remain_exit) begin
                    phase_next      = 1'b0;
                    res_status_next = STAT_SUCCEEDED;
                end else begin
                    rem_next = remaining[15:0];
                end
            end
            ST_MUL: begin
                prod_next = {accel_reg, 1'b0} * rem_reg;
            end
            ST_ROOT_GO: begin
                sq_ctrl.start = 1'b1;
            end
            ST_CLAMP: begin
                if (coll_reg) begin
                    phase_next      = 1'b0;
                    res_status_next = STAT_COLLISION;
                end else begin
                    res_status_next = STAT_RUNNING;
                    res_vel_next    = cmd_reg[16] ? 16'(-signed'(v_clamp))
                                                  : signed'(v_clamp);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {3'b000, acc_reg, res_vel_reg, res_status_reg};
                end
            end
            default: ;
        endcase
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= 1'b0;
            prev_yaw_reg  <= '0;
            acc_reg       <= '0;
            cmd_reg       <= '0;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
            target_reg    <= TARGET_ANGLE_RST;
            vmax_reg      <= MAX_VELOCITY_RST;
            vmin_reg      <= MIN_VELOCITY_RST;
            accel_reg     <= ACCEL_LIMIT_RST;
            tmo_reg       <= TIME_ALLOW_RST;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            prev_yaw_reg  <= prev_yaw_next;
            acc_reg       <= acc_next;
            cmd_reg       <= cmd_next;
            elapsed_reg   <= elapsed_next;
            out_valid_reg <= out_valid_next;
            // configuration write transaction
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TARGET_ANGLE: target_reg <= cfg_data[14:0];
                    CFG_MAX_VELOCITY: vmax_reg   <= cfg_data[14:0];
                    CFG_MIN_VELOCITY: vmin_reg   <= cfg_data[14:0];
                    CFG_ACCEL_LIMIT:  accel_reg  <= cfg_data[14:0];
                    CFG_TIME_ALLOW:   tmo_reg    <= cfg_data;
                    default: ;
                endcase
            end
        end
        // input capture on an accepted transaction
        if (s_acc) begin
            act_reg  <= s_tuser;
            yaw_reg  <= signed'(s_tdata[14:0]);
            turn_reg <= s_tdata[15];
            goal_reg <= signed'(s_tdata[31:16]);
            coll_reg <= s_tdata[32];
        end
        rem_reg        <= rem_next;
        prod_reg       <= prod_next;
        res_status_reg <= res_status_next;
        res_vel_reg    <= res_vel_next;
        out_data_reg   <= out_data_next;
    end

    spvp_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (sq_ctrl),
        .radicand (prod_reg),
        .stat     (sq_stat),
        .root     (sq_root)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### hdl/spvp_checker.sv
// port-level checks on the rotation controller, bound to the top level
// depends on spvp_pkg for the status codes and payload widths
`timescale 1ns / 1ps

module spvp_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [spvp_pkg::M_TDATA_W-1:0] m_tdata
);
    import spvp_pkg::*;

    // no result pending straight after reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // one item at a time: busy right after an accepted input transaction
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // status code is a defined one
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] == STAT_IDLE || m_tdata[2:0] == STAT_RUNNING ||
                      m_tdata[2:0] == STAT_SUCCEEDED || m_tdata[2:0] == STAT_TIMED_OUT ||
                      m_tdata[2:0] == STAT_COLLISION))
        else $error("undefined status code");

    // speed is commanded only while running
    a_stopped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] != STAT_RUNNING |-> m_tdata[18:3] == 16'd0)
        else $error("nonzero speed while stopped");

endmodule

bind spin_in_place_velocity_profile spvp_checker u_spvp_checker (.*);
